/* design/sorted_table_binary_search_core_macros.svh */
// Assertion macros shared by the sorted table search design.
`ifndef SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define STBS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");
`define STBS_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define STBS_ASSERT(label, clk, rst, prop)
`define STBS_NEVER(label, clk, rst, expr)
`endif

`endif

/* design/stbs_pkg.sv */
// Shared constants, codes and controller/datapath command types.
`timescale 1ns / 1ps

package stbs_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int POS_WIDTH   = 4;
   localparam int CSR_DATA_WIDTH = 4;
   // bound registers one wider than an index so an empty range can be held
   localparam int BOUND_WIDTH = POS_WIDTH + 1;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam logic CSR_RANGE_FIRST = 1'b0;
   localparam logic CSR_RANGE_LAST  = 1'b1;

   localparam logic [POS_WIDTH-1:0] RANGE_FIRST_RESET = '0;
   localparam logic [POS_WIDTH-1:0] RANGE_LAST_RESET  = POS_WIDTH'(TABLE_DEPTH - 1);
   localparam logic [POS_WIDTH-1:0] INDEX_MAX         = POS_WIDTH'(TABLE_DEPTH - 1);

   typedef struct packed {
      logic tbl_write;
      logic load;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic hit;
      logic next_empty;
      logic out_free;
   } status_type;

endpackage

/* design/stbs_ifs.sv */
// Channel interfaces: search/write requests, search results, register writes.
`timescale 1ns / 1ps

interface stbs_req_if;
   logic                                     valid;
   logic                                     ready;
   logic                                     op;
   logic        [stbs_pkg::POS_WIDTH-1:0]    entry_index;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0]  entry_value;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0]  search_key;

   modport source (output valid, output op, output entry_index, output entry_value,
                   output search_key, input ready);
   modport sink (input valid, input op, input entry_index, input entry_value,
                 input search_key, output ready);
endinterface

interface stbs_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            found;
   logic [stbs_pkg::POS_WIDTH-1:0]  position;

   modport source (output valid, output found, output position, input ready);
   modport sink (input valid, input found, input position, output ready);
endinterface

interface stbs_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 index;
   logic [stbs_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

/* design/stbs_ctrl.sv */
// Search controller: accepts requests and sequences the table probes.
`timescale 1ns / 1ps

module stbs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  stbs_pkg::status_type status,
   output stbs_pkg::cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.tbl_write = 1'b0;
      cmd.load      = 1'b0;
      cmd.step      = 1'b0;
      cmd.finish    = 1'b0;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == stbs_pkg::OP_SEARCH) begin
                  cmd.load = 1'b1;
                  state_in = ST_PROBE;
               end else begin
                  cmd.tbl_write = 1'b1;
               end
            end
         end
         ST_PROBE: begin
            if (status.empty || status.hit || status.next_empty) begin
               if (status.out_free) begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* design/stbs_datapath.sv */
// Search datapath: range registers, entry table, probe bounds and result register.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_core_macros.svh"

module stbs_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  stbs_pkg::cmd_type                       cmd,
   output stbs_pkg::status_type                    status,
   input  logic                                    csr_write,
   input  logic                                    csr_index,
   input  logic        [stbs_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   input  logic        [stbs_pkg::POS_WIDTH-1:0]   entry_index,
   input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] entry_value,
   input  logic signed [stbs_pkg::VALUE_WIDTH-1:0] search_key,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_found,
   output logic        [stbs_pkg::POS_WIDTH-1:0]   rsp_position
);

   logic        [stbs_pkg::POS_WIDTH-1:0]   range_first_ff;
   logic        [stbs_pkg::POS_WIDTH-1:0]   range_last_ff;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] table_ff [stbs_pkg::TABLE_DEPTH];
   logic        [stbs_pkg::BOUND_WIDTH-1:0] lo_ff;
   logic        [stbs_pkg::BOUND_WIDTH-1:0] hi1_ff;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] key_ff;
   logic                                    rsp_valid_ff;
   logic                                    found_ff;
   logic        [stbs_pkg::POS_WIDTH-1:0]   position_ff;

   logic        [stbs_pkg::POS_WIDTH-1:0]   last_clamped;
   logic        [stbs_pkg::BOUND_WIDTH-1:0] mid_sum;
   logic        [stbs_pkg::POS_WIDTH-1:0]   mid;
   logic signed [stbs_pkg::VALUE_WIDTH-1:0] probe;
   logic                                    probe_gt;
   logic        [stbs_pkg::BOUND_WIDTH-1:0] lo_in;
   logic        [stbs_pkg::BOUND_WIDTH-1:0] hi1_in;
   logic                                    found_in;

   assign last_clamped = (range_last_ff > stbs_pkg::INDEX_MAX) ? stbs_pkg::INDEX_MAX
                                                               : range_last_ff;

   // floor((lo + hi) / 2) with hi held as hi + 1
   assign mid_sum  = stbs_pkg::BOUND_WIDTH'(lo_ff + hi1_ff - 1'b1);
   assign mid      = mid_sum[stbs_pkg::BOUND_WIDTH-1:1];
   assign probe    = table_ff[mid];
   assign probe_gt = probe > key_ff;

   always_comb begin
      lo_in  = lo_ff;
      hi1_in = hi1_ff;
      if (probe_gt) begin
         hi1_in = {1'b0, mid};
      end else begin
         lo_in = stbs_pkg::BOUND_WIDTH'({1'b0, mid} + 1'b1);
      end
   end

   assign status.empty      = lo_ff >= hi1_ff;
   assign status.hit        = probe == key_ff;
   assign status.next_empty = lo_in >= hi1_in;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign found_in = status.hit && !status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_first_ff <= stbs_pkg::RANGE_FIRST_RESET;
         range_last_ff  <= stbs_pkg::RANGE_LAST_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            stbs_pkg::CSR_RANGE_FIRST: range_first_ff <= csr_data;
            stbs_pkg::CSR_RANGE_LAST:  range_last_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.tbl_write) begin
         table_ff[entry_index] <= entry_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lo_ff  <= {1'b0, range_first_ff};
         hi1_ff <= stbs_pkg::BOUND_WIDTH'({1'b0, last_clamped} + 1'b1);
         key_ff <= search_key;
      end else if (cmd.step) begin
         lo_ff  <= lo_in;
         hi1_ff <= hi1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         found_ff    <= found_in;
         position_ff <= found_in ? mid : '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;

   `STBS_ASSERT(a_finish_needs_room, clock, reset, cmd.finish |-> status.out_free)
   `STBS_NEVER(a_no_step_on_empty, clock, reset, cmd.step && status.empty)
   `STBS_ASSERT(a_miss_has_zero_pos, clock, reset,
                rsp_valid_ff && !found_ff |-> position_ff == '0)
   `STBS_ASSERT(a_hit_reported, clock, reset,
                cmd.finish && found_in |=> rsp_valid_ff && found_ff && position_ff == $past(mid))

endmodule

/* design/sorted_table_binary_search_core.sv */
// Write: accepted with no result beat. Search: one table probe per cycle,
// up to 5 probes for 16 entries, after which the result beat is registered;
// the controller is back in idle, ready for the next request, as the beat appears.
// A pending result beat stalls only the finish of the next search.
// Reset: range_first to 0, range_last to 15, controller idle, no result pending;
// table entries are undefined until written.
`timescale 1ns / 1ps

module sorted_table_binary_search_core (
   input logic         clock,
   input logic         reset,
   stbs_req_if.sink    req_bus,
   stbs_rsp_if.source  rsp_bus,
   stbs_csr_if.sink    csr_bus
);

   stbs_pkg::cmd_type    cmd;
   stbs_pkg::status_type status;

   assign csr_bus.ready = 1'b1;

   stbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   stbs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .entry_index  (req_bus.entry_index),
      .entry_value  (req_bus.entry_value),
      .search_key   (req_bus.search_key),
      .rsp_valid    (rsp_bus.valid),
      .rsp_ready    (rsp_bus.ready),
      .rsp_found    (rsp_bus.found),
      .rsp_position (rsp_bus.position)
   );

endmodule
